// File: hw/rtl/acb_pkg.sv
`default_nettype none

package acb_pkg;

	// Frame store geometry.
	localparam int FRAME_BYTES = 32;
	localparam int FRAME_AW    = $clog2(FRAME_BYTES);
	localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
	localparam int HINT_LEN    = 25;
	localparam int DIGITS      = 20;

	// Result kinds.
	localparam logic [1:0] KIND_TX    = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	// Characters with a meaning in the frame grammar.
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_QUERY = 8'h3f;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef struct packed {
		logic        command;
		logic [7:0]  rx_byte;
		logic [15:0] read_data;
		logic        read_error;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [15:0] reg_address;
		logic [15:0] write_data;
		logic        last;
	} out_item_t;

	// Character of the help hint at a given position.
	function automatic logic [7:0] hint_char(input logic [4:0] idx);
		logic [7:0] c;
		case (idx)
			5'd0:  c = "S";
			5'd1:  c = "e";
			5'd2:  c = "n";
			5'd3:  c = "d";
			5'd4:  c = " ";
			5'd5:  c = "R";
			5'd6:  c = "E";
			5'd7:  c = "G";
			5'd8:  c = ":";
			5'd9:  c = "0";
			5'd10: c = "0";
			5'd11: c = "0";
			5'd12: c = "0";
			5'd13: c = "0";
			5'd14: c = "?";
			5'd15: c = " ";
			5'd16: c = "f";
			5'd17: c = "o";
			5'd18: c = "r";
			5'd19: c = " ";
			5'd20: c = "h";
			5'd21: c = "e";
			5'd22: c = "l";
			5'd23: c = "p";
			5'd24: c = 8'h0a;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Weight of an address digit by its frame position.
	function automatic logic [15:0] digit_weight(input logic [3:0] pos);
		logic [15:0] w;
		case (pos)
			4'd4:    w = 16'd10000;
			4'd5:    w = 16'd1000;
			4'd6:    w = 16'd100;
			4'd7:    w = 16'd10;
			default: w = 16'd1;
		endcase
		return w;
	endfunction

	function automatic logic is_quad(input logic [15:0] a);
		return a == 16'd40604 || a == 16'd40608 || a == 16'd40612 || a == 16'd40616 ||
			a == 16'd40620 || a == 16'd40624 || a == 16'd40628;
	endfunction

	function automatic logic [2:0] read_words(input logic [15:0] a);
		logic [2:0] n;
		if (a == 16'd30201 || a == 16'd30208 || a == 16'd40301 || a == 16'd40632 ||
			a == 16'd40634) begin
			n = 3'd2;
		end else if (is_quad(a)) begin
			n = 3'd4;
		end else begin
			n = 3'd1;
		end
		return n;
	endfunction

	function automatic logic [2:0] write_words(input logic [15:0] a);
		logic [2:0] n;
		if (a == 16'd40301 || a == 16'd40632 || a == 16'd40634) begin
			n = 3'd2;
		end else if (is_quad(a)) begin
			n = 3'd4;
		end else begin
			n = 3'd1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/acb_if.sv
`default_nettype none

// Input channel: serial bytes and read responses.
interface acb_in_if;
	logic              valid;
	logic              ready;
	acb_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// Output channel: transmit bytes and register requests.
interface acb_out_if;
	logic               valid;
	logic               ready;
	acb_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/acb_frame_mem.sv
`default_nettype none

module acb_frame_mem (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [acb_pkg::FRAME_AW-1:0] waddr,
	input  wire logic [7:0]                   wdata,
	input  wire logic [acb_pkg::FRAME_AW-1:0] raddr,
	output logic      [7:0]                   rdata
);

	logic [7:0] mem [acb_pkg::FRAME_BYTES];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/ascii_register_command_bridge.sv
`default_nettype none

// Channel  Dir  Payload                                          Handshake
// cmd      in   command, rx_byte, read_data, read_error          valid/ready
// res      out  kind, tx_byte, reg_address, write_data, last     valid/ready
//
// A plain byte is accepted straight into the frame store; cmd is ready only while the sequencer is idle.
// A finished frame is read back byte by byte: ten header bytes (0 to 8 and the last byte),
// then a backward scan for the space or sign and a forward decimal pass, then the results.
// A response that needs another word issues the next read; the last word starts a binary to
// decimal conversion of the 64-bit magnitude, skips leading zeros, then emits up to 21 bytes.
// Reset clears all control state; the frame memory needs no clearing.
// A stalled result register holds the sequencer in a state that emits; the next item waits on cmd.ready.
module ascii_register_command_bridge (
	input wire logic clk,
	input wire logic arst_n,
	acb_in_if.sink   cmd,
	acb_out_if.source res
);

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_HINT   = 16'h0002,
		S_HREQ   = 16'h0004,
		S_HDAT   = 16'h0008,
		S_RDREQ  = 16'h0010,
		S_BREQ   = 16'h0020,
		S_BDAT   = 16'h0040,
		S_FREQ   = 16'h0080,
		S_FDAT   = 16'h0100,
		S_WR     = 16'h0200,
		S_RDNEXT = 16'h0400,
		S_CONV   = 16'h0800,
		S_SIGN   = 16'h1000,
		S_SKIP   = 16'h2000,
		S_DIG    = 16'h4000,
		S_NL     = 16'h8000
	} state_t;

	state_t                          state_q;
	logic [acb_pkg::LEN_W-1:0]       len_q;
	logic [acb_pkg::LEN_W-1:0]       flen_q;
	logic [acb_pkg::LEN_W-1:0]       pos_q;
	logic [4:0]                      idx_q;
	logic [15:0]                     addr_q;
	logic [15:0]                     pending_q;
	logic [2:0]                      fetched_q;
	logic                            awaiting_q;
	logic                            neg_q;
	logic [63:0]                     acc_q;
	logic [63:0]                     val_q;
	logic [63:0]                     bin_q;
	logic [4*acb_pkg::DIGITS-1:0]    bcd_q;
	logic [6:0]                      cnt_q;
	logic                            sign_q;
	logic [1:0]                      wi_q;
	logic                            ov_q;
	acb_pkg::out_item_t              out_q;

	logic                            mem_we;
	logic [acb_pkg::FRAME_AW-1:0]    mem_waddr;
	logic [7:0]                      mem_wdata;
	logic [acb_pkg::FRAME_AW-1:0]    mem_raddr;
	logic [7:0]                      mem_rdata;

	logic                            out_free;
	logic                            emit;
	acb_pkg::out_item_t              emit_item;
	logic                            in_acc;
	logic [2:0]                      rn;
	logic [2:0]                      wn;
	logic [1:0]                      wsel;
	logic [63:0]                     acc_next;
	logic [2:0]                      fetched_next;
	logic [3:0]                      cur_digit;
	logic [4*acb_pkg::DIGITS-1:0]    bcd_adj;
	logic [63:0]                     val_x10;
	logic [8:0]                      dig_diff;
	logic                            hdr_bad;

	acb_frame_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign in_acc    = cmd.valid && cmd.ready;
	assign out_free  = !ov_q || res.ready;
	assign res.valid = ov_q;
	assign res.item  = out_q;

	// Frame byte store, written only from idle.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = len_q[acb_pkg::FRAME_AW-1:0];
		mem_wdata = cmd.item.rx_byte;
		if (in_acc && !cmd.item.command && !awaiting_q) begin
			if (cmd.item.rx_byte == acb_pkg::CH_R) begin
				mem_we    = 1'b1;
				mem_waddr = '0;
			end else if (cmd.item.rx_byte != acb_pkg::CH_NL &&
				len_q < acb_pkg::LEN_W'(acb_pkg::FRAME_BYTES)) begin
				mem_we = 1'b1;
			end
		end
	end

	// Read address for the sequencer.
	always_comb begin
		case (state_q)
			S_HREQ: begin
				mem_raddr = (idx_q < 5'd9) ? acb_pkg::FRAME_AW'(idx_q) :
					acb_pkg::FRAME_AW'(flen_q - 1'b1);
			end
			default: mem_raddr = pos_q[acb_pkg::FRAME_AW-1:0];
		endcase
	end

	// Header check of the frame byte just read.
	always_comb begin
		case (idx_q)
			5'd0:    hdr_bad = (mem_rdata != acb_pkg::CH_R);
			5'd1:    hdr_bad = (mem_rdata != acb_pkg::CH_E);
			5'd2:    hdr_bad = (mem_rdata != acb_pkg::CH_G);
			5'd3:    hdr_bad = (mem_rdata != acb_pkg::CH_COLON);
			default: hdr_bad = 1'b0;
		endcase
	end

	// Read response merge into the accumulator.
	assign rn = acb_pkg::read_words(pending_q);
	always_comb begin
		case (rn)
			3'd2: begin
				if (fetched_q == 3'd0) begin
					acc_next = {{32{cmd.item.read_data[15]}}, cmd.item.read_data, 16'h0000};
				end else begin
					acc_next = acc_q | {{48{cmd.item.read_data[15]}}, cmd.item.read_data};
				end
			end
			3'd4: begin
				acc_next = acc_q | ({48'h0, cmd.item.read_data} << {~fetched_q[1:0], 4'b0000});
			end
			default: acc_next = {48'h0, cmd.item.read_data};
		endcase
	end
	assign fetched_next = fetched_q + 3'd1;

	// Decimal helpers.
	always_comb begin
		for (int d = 0; d < acb_pkg::DIGITS; d++) begin
			bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3 :
				bcd_q[4*d +: 4];
		end
	end
	assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];
	assign dig_diff  = {1'b0, mem_rdata} - 9'h030;
	assign val_x10   = (val_q << 3) + (val_q << 1) + {{55{dig_diff[8]}}, dig_diff};

	// Word selection for writes, most significant first.
	assign wn   = acb_pkg::write_words(addr_q);
	assign wsel = 2'(wn - 3'd1 - {1'b0, wi_q});

	// Result to emit in the current state.
	always_comb begin
		emit      = 1'b0;
		emit_item = '0;
		case (state_q)
			S_HINT: begin
				emit              = 1'b1;
				emit_item.tx_byte = acb_pkg::hint_char(idx_q);
				emit_item.last    = (idx_q == 5'(acb_pkg::HINT_LEN - 1));
			end
			S_RDREQ: begin
				emit                  = 1'b1;
				emit_item.kind        = acb_pkg::KIND_READ;
				emit_item.reg_address = addr_q;
				emit_item.last        = 1'b1;
			end
			S_RDNEXT: begin
				emit                  = 1'b1;
				emit_item.kind        = acb_pkg::KIND_READ;
				emit_item.reg_address = pending_q + {13'h0, fetched_q};
				emit_item.last        = 1'b1;
			end
			S_WR: begin
				emit                  = 1'b1;
				emit_item.kind        = acb_pkg::KIND_WRITE;
				emit_item.reg_address = addr_q + {14'h0, wi_q};
				emit_item.write_data  = val_q[{wsel, 4'b0000} +: 16];
				emit_item.last        = ({1'b0, wi_q} == wn - 3'd1);
			end
			S_SIGN: begin
				emit              = 1'b1;
				emit_item.tx_byte = sign_q ? acb_pkg::CH_MINUS : acb_pkg::CH_SPACE;
			end
			S_DIG: begin
				emit              = 1'b1;
				emit_item.tx_byte = acb_pkg::CH_ZERO | {4'h0, cur_digit};
			end
			S_NL: begin
				emit              = 1'b1;
				emit_item.tx_byte = acb_pkg::CH_NL;
				emit_item.last    = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit && out_free) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			out_q <= emit_item;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_q      <= '0;
			flen_q     <= '0;
			pos_q      <= '0;
			idx_q      <= '0;
			addr_q     <= '0;
			pending_q  <= '0;
			fetched_q  <= '0;
			awaiting_q <= 1'b0;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			val_q      <= '0;
			bin_q      <= '0;
			bcd_q      <= '0;
			cnt_q      <= '0;
			sign_q     <= 1'b0;
			wi_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && cmd.item.command && awaiting_q) begin
						if (fetched_q == 3'd0 && cmd.item.read_error) begin
							awaiting_q <= 1'b0;
						end else begin
							acc_q     <= acc_next;
							fetched_q <= fetched_next;
							if (fetched_next < rn) begin
								state_q <= S_RDNEXT;
							end else begin
								awaiting_q <= 1'b0;
								sign_q     <= acc_next[63];
								bin_q      <= acc_next[63] ? 64'h0 - acc_next : acc_next;
								bcd_q      <= '0;
								cnt_q      <= '0;
								state_q    <= S_CONV;
							end
						end
					end else if (in_acc && !cmd.item.command && !awaiting_q) begin
						if (cmd.item.rx_byte == acb_pkg::CH_R) begin
							len_q <= acb_pkg::LEN_W'(1);
						end else if (cmd.item.rx_byte == acb_pkg::CH_NL) begin
							flen_q <= len_q;
							len_q  <= '0;
							idx_q  <= '0;
							addr_q <= '0;
							state_q <= (len_q < acb_pkg::LEN_W'(10)) ? S_HINT : S_HREQ;
						end else if (len_q < acb_pkg::LEN_W'(acb_pkg::FRAME_BYTES)) begin
							len_q <= len_q + 1'b1;
						end
					end
				end
				S_HINT: begin
					if (out_free) begin
						idx_q <= idx_q + 5'd1;
						if (idx_q == 5'(acb_pkg::HINT_LEN - 1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_HREQ: state_q <= S_HDAT;
				S_HDAT: begin
					if (hdr_bad) begin
						idx_q   <= '0;
						state_q <= S_HINT;
					end else if (idx_q == 5'd9) begin
						if (mem_rdata == acb_pkg::CH_QUERY) begin
							state_q <= S_RDREQ;
						end else begin
							pos_q   <= flen_q - 1'b1;
							neg_q   <= 1'b0;
							state_q <= S_BREQ;
						end
					end else begin
						idx_q   <= idx_q + 5'd1;
						state_q <= S_HREQ;
						if (idx_q inside {[5'd4:5'd8]}) begin
							addr_q <= addr_q + 16'(({8'h00, mem_rdata} - 16'h0030) *
								acb_pkg::digit_weight(idx_q[3:0]));
						end
					end
				end
				S_RDREQ: begin
					if (out_free) begin
						pending_q  <= addr_q;
						fetched_q  <= '0;
						acc_q      <= '0;
						awaiting_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_BREQ: begin
					if (pos_q < acb_pkg::LEN_W'(10)) begin
						pos_q   <= acb_pkg::LEN_W'(10);
						val_q   <= '0;
						state_q <= S_FREQ;
					end else begin
						state_q <= S_BDAT;
					end
				end
				S_BDAT: begin
					if (mem_rdata == acb_pkg::CH_SPACE || mem_rdata == acb_pkg::CH_MINUS) begin
						neg_q   <= (mem_rdata == acb_pkg::CH_MINUS);
						pos_q   <= pos_q + 1'b1;
						val_q   <= '0;
						state_q <= S_FREQ;
					end else begin
						pos_q   <= pos_q - 1'b1;
						state_q <= S_BREQ;
					end
				end
				S_FREQ: begin
					if (pos_q == flen_q) begin
						val_q   <= neg_q ? 64'h0 - val_q : val_q;
						wi_q    <= '0;
						state_q <= S_WR;
					end else begin
						state_q <= S_FDAT;
					end
				end
				S_FDAT: begin
					val_q   <= val_x10;
					pos_q   <= pos_q + 1'b1;
					state_q <= S_FREQ;
				end
				S_WR: begin
					if (out_free) begin
						wi_q <= wi_q + 2'd1;
						if ({1'b0, wi_q} == wn - 3'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RDNEXT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_CONV: begin
					{bcd_q, bin_q} <= {bcd_adj, bin_q} << 1;
					cnt_q          <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) begin
						idx_q   <= 5'(acb_pkg::DIGITS - 1);
						state_q <= S_SIGN;
					end
				end
				S_SIGN: begin
					if (out_free) begin
						state_q <= S_SKIP;
					end
				end
				S_SKIP: begin
					if (cur_digit == 4'd0 && idx_q != 5'd0) begin
						idx_q <= idx_q - 5'd1;
					end else begin
						state_q <= S_DIG;
					end
				end
				S_DIG: begin
					if (out_free) begin
						if (idx_q == 5'd0) begin
							state_q <= S_NL;
						end else begin
							idx_q <= idx_q - 5'd1;
						end
					end
				end
				S_NL: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A byte arriving during an outstanding read leaves the frame untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !cmd.item.command && awaiting_q) |=> $stable(len_q))
		else $error("frame length changed during an outstanding read");

	// A response arriving with no read outstanding produces nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cmd.item.command && !awaiting_q) |=> (state_q == S_IDLE))
		else $error("unexpected response started work");

	// A read request is always the final result of its transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.item.kind == acb_pkg::KIND_READ) |-> res.item.last)
		else $error("read request not marked last");

endmodule

`default_nettype wire
